// File: design/sll_pkg.sv
`default_nettype none

package sll_pkg;

  localparam int NODES    = 128;
  localparam int LINK_W   = $clog2(NODES);
  localparam int OP_W     = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [LINK_W-1:0] HEAD_FREE = LINK_W'(0);
  localparam logic [LINK_W-1:0] HEAD_LIST = LINK_W'(NODES - 1);
  localparam logic [COUNT_W-1:0] MAX_ENTRIES = COUNT_W'(NODES - 2);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              we;
    logic [LINK_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic [LINK_W-1:0] raddr;
  } link_req_t;

  typedef struct packed {
    logic              we;
    logic [LINK_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [LINK_W-1:0] raddr;
  } val_req_t;

endpackage

`default_nettype wire

// File: design/sll_ram.sv
`default_nettype none

module sll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: design/sll_ctrl.sv
`default_nettype none

module sll_ctrl (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [sll_pkg::OP_W-1:0]           op_i,
  input  wire logic [sll_pkg::POS_W-1:0]          position_i,
  input  wire logic signed [sll_pkg::VAL_W-1:0]   value_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output logic [sll_pkg::STATUS_W-1:0]            status_o,
  output logic signed [sll_pkg::VAL_W-1:0]        read_value_o,
  output logic [sll_pkg::COUNT_W-1:0]             count_o,
  output sll_pkg::link_req_t                      link_req_o,
  input  wire logic [sll_pkg::LINK_W-1:0]         link_rdata_i,
  output sll_pkg::val_req_t                       val_req_o,
  input  wire logic [sll_pkg::VAL_W-1:0]          val_rdata_i
);

  import sll_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_FREE, S_WALK, S_TAIL, S_WR1, S_WR2
  } state_e;

  state_e               state_q;
  logic [LINK_W-1:0]    init_q;
  logic [OP_W-1:0]      op_q;
  logic [VAL_W-1:0]     val_q;
  logic [LINK_W-1:0]    free_q;   // head of free chain (insert: new slot)
  logic [LINK_W-1:0]    cur_q;    // address of the link read in flight
  logic [POS_W-1:0]     rem_q;    // hops left after the one in flight
  logic [LINK_W-1:0]    prev_q;
  logic [LINK_W-1:0]    nxt_q;    // link of prev: successor / victim
  logic [COUNT_W-1:0]   count_q;
  logic                 done_q;
  logic [STATUS_W-1:0]  status_q;
  logic [VAL_W-1:0]     rdval_q;

  logic range_bad;
  logic full;

  always_comb begin
    if (op_i == OP_INSERT) begin
      range_bad = (position_i == '0) ||
                  ({1'b0, position_i} > ({1'b0, count_q} + (COUNT_W+1)'(1)));
    end else begin
      range_bad = (position_i == '0) || (position_i > count_q);
    end
    full = (count_q == MAX_ENTRIES);
  end

  // Memory port drive; all reads of an item finish before its first write,
  // and busy holds off the next item until the last write is done.
  always_comb begin
    link_req_o = '0;
    val_req_o  = '0;
    case (state_q)
      S_INIT: begin
        link_req_o.we    = 1'b1;
        link_req_o.waddr = init_q;
        link_req_o.wdata = (init_q < LINK_W'(NODES - 2)) ? init_q + LINK_W'(1) : '0;
      end
      S_IDLE: begin
        link_req_o.raddr = HEAD_FREE;
      end
      S_FREE: begin
        link_req_o.raddr = HEAD_LIST;
      end
      S_WALK: begin
        if (rem_q == '0 && op_q == OP_INSERT) begin
          link_req_o.raddr = free_q;
        end else begin
          link_req_o.raddr = link_rdata_i;
        end
        val_req_o.raddr = link_rdata_i;
      end
      S_TAIL: begin
        if (op_q == OP_INSERT) begin
          link_req_o.we    = 1'b1;
          link_req_o.waddr = HEAD_FREE;
          link_req_o.wdata = link_rdata_i;
          val_req_o.we     = 1'b1;
          val_req_o.waddr  = free_q;
          val_req_o.wdata  = val_q;
        end else if (op_q == OP_DELETE) begin
          link_req_o.we    = 1'b1;
          link_req_o.waddr = prev_q;
          link_req_o.wdata = link_rdata_i;
        end
      end
      S_WR1: begin
        link_req_o.we = 1'b1;
        if (op_q == OP_INSERT) begin
          link_req_o.waddr = free_q;
          link_req_o.wdata = nxt_q;
        end else begin
          link_req_o.waddr = nxt_q;
          link_req_o.wdata = free_q;
        end
      end
      S_WR2: begin
        link_req_o.we = 1'b1;
        if (op_q == OP_INSERT) begin
          link_req_o.waddr = prev_q;
          link_req_o.wdata = free_q;
        end else begin
          link_req_o.waddr = HEAD_FREE;
          link_req_o.wdata = nxt_q;
        end
      end
      default: begin
        link_req_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      init_q   <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      rdval_q  <= '0;
      op_q     <= '0;
      val_q    <= '0;
      free_q   <= '0;
      cur_q    <= '0;
      rem_q    <= '0;
      prev_q   <= '0;
      nxt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          init_q <= init_q + LINK_W'(1);
          if (init_q == HEAD_LIST) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            op_q  <= op_i;
            val_q <= value_i;
            rem_q <= position_i - POS_W'(1);
            if (op_i != OP_INSERT && op_i != OP_DELETE && op_i != OP_READ) begin
              done_q   <= 1'b1;
              status_q <= ST_OK;
              rdval_q  <= '0;
            end else if (range_bad) begin
              done_q   <= 1'b1;
              status_q <= ST_RANGE;
              rdval_q  <= '0;
            end else if (op_i == OP_INSERT && full) begin
              done_q   <= 1'b1;
              status_q <= ST_FULL;
              rdval_q  <= '0;
            end else begin
              state_q <= S_FREE;
            end
          end
        end
        S_FREE: begin
          free_q  <= link_rdata_i;
          cur_q   <= HEAD_LIST;
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (rem_q == '0) begin
            prev_q  <= cur_q;
            nxt_q   <= link_rdata_i;
            state_q <= S_TAIL;
          end else begin
            cur_q <= link_rdata_i;
            rem_q <= rem_q - POS_W'(1);
          end
        end
        S_TAIL: begin
          if (op_q == OP_READ) begin
            done_q   <= 1'b1;
            status_q <= ST_OK;
            rdval_q  <= val_rdata_i;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_WR1;
          end
        end
        S_WR1: begin
          state_q <= S_WR2;
        end
        S_WR2: begin
          done_q   <= 1'b1;
          status_q <= ST_OK;
          rdval_q  <= '0;
          if (op_q == OP_INSERT) begin
            count_q <= count_q + COUNT_W'(1);
          end else begin
            count_q <= count_q - COUNT_W'(1);
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rdval_q;
  assign count_o      = count_q;

endmodule

`default_nettype wire

// File: design/static_linked_list_engine_top.sv
`default_nettype none
// done_o follows the walk and the link writes for an insert or delete, the walk for
// a read; a rejected request or unused op code gets it in the cycle after acceptance.
// Throughput: one request at a time, set by the link walk (one read of the link
// memory per hop, up to 126 hops); a new start may be taken while done_o shows.
// Reset: busy_o stays high while the link memory is swept to its initial free
// chain; the receiver cannot stall and done_o lasts one cycle.

module static_linked_list_engine_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [sll_pkg::OP_W-1:0]           op_i,
  input  wire logic [sll_pkg::POS_W-1:0]          position_i,
  input  wire logic signed [sll_pkg::VAL_W-1:0]   value_i,
  output logic                                    done_o,
  output logic [sll_pkg::STATUS_W-1:0]            status_o,
  output logic signed [sll_pkg::VAL_W-1:0]        read_value_o,
  output logic [sll_pkg::COUNT_W-1:0]             count_o
);

  import sll_pkg::*;

  link_req_t         link_req;
  val_req_t          val_req;
  logic [LINK_W-1:0] link_rdata;
  logic [VAL_W-1:0]  val_rdata;

  sll_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .op_i         (op_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o),
    .link_req_o   (link_req),
    .link_rdata_i (link_rdata),
    .val_req_o    (val_req),
    .val_rdata_i  (val_rdata)
  );

  sll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NODES)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (link_req.we),
    .waddr_i (link_req.waddr),
    .wdata_i (link_req.wdata),
    .raddr_i (link_req.raddr),
    .rdata_o (link_rdata)
  );

  sll_ram #(
    .WIDTH (VAL_W),
    .DEPTH (NODES)
  ) u_val_mem (
    .clk_i   (clk_i),
    .we_i    (val_req.we),
    .waddr_i (val_req.waddr),
    .wdata_i (val_req.wdata),
    .raddr_i (val_req.raddr),
    .rdata_o (val_rdata)
  );

endmodule

`default_nettype wire

// File: design/sll_checker.sv
`default_nettype none

module sll_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start_i,
  input wire logic                               busy_o,
  input wire logic [sll_pkg::POS_W-1:0]          position_i,
  input wire logic                               done_o,
  input wire logic [sll_pkg::STATUS_W-1:0]       status_o,
  input wire logic signed [sll_pkg::VAL_W-1:0]   read_value_o,
  input wire logic [sll_pkg::COUNT_W-1:0]        count_o
);

  import sll_pkg::*;

  // Position zero is answered in the cycle right after the transfer.
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && position_i == '0 |=> done_o)
    else $error("position zero not answered at once");

  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> $stable(count_o))
    else $error("rejected request changed the entry count");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> count_o <= MAX_ENTRIES)
    else $error("entry count beyond store capacity");

  a_rdval_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && read_value_o != 0 |-> status_o == ST_OK)
    else $error("read value shown with error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o == ST_OK || status_o == ST_RANGE || status_o == ST_FULL)
    else $error("unknown status code");

endmodule

bind static_linked_list_engine_top sll_checker u_sll_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .position_i   (position_i),
  .done_o       (done_o),
  .status_o     (status_o),
  .read_value_o (read_value_o),
  .count_o      (count_o)
);

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
  import sll_pkg::*;

  // op code the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1200;
  localparam int PHASE_ITEMS  = 200;

  typedef enum int {GROW, CHURN, SHRINK} traffic_mode_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    rd;
    logic [COUNT_W-1:0]  count;
  } answer_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [OP_W-1:0]          req_op = OP_INSERT;
  logic [POS_W-1:0]         req_pos = '0;
  logic signed [VAL_W-1:0]  req_value = '0;
  logic                     busy;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic signed [VAL_W-1:0]  read_value;
  logic [COUNT_W-1:0]       count;

  static_linked_list_engine_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .op_i         (req_op),
    .position_i   (req_pos),
    .value_i      (req_value),
    .done_o       (done),
    .status_o     (status),
    .read_value_o (read_value),
    .count_o      (count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow of the node store
  logic [LINK_W-1:0] links [NODES];
  logic [VAL_W-1:0]  values [NODES];
  int                entries;

  request_t request_queue[$];
  answer_t  pending_answers[$];
  int       total_items = 0;
  int       gen_count = 0;
  int       issued = 0;
  int       accepted = 0;
  int       gap_left = 0;
  int       errors = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;

  function automatic logic [LINK_W-1:0] hop_from_head(int steps);
    logic [LINK_W-1:0] slot;
    slot = HEAD_LIST;
    for (int k = 0; k < steps; k++) slot = links[slot];
    return slot;
  endfunction

  function automatic answer_t list_apply(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                         logic [VAL_W-1:0] val);
    answer_t           a;
    logic [LINK_W-1:0] prev;
    logic [LINK_W-1:0] slot;
    a = '0;
    case (op)
      OP_INSERT: begin
        if (pos == 0 || int'(pos) > entries + 1) begin
          a.status = ST_RANGE;
        end else if (links[HEAD_FREE] == HEAD_FREE) begin
          a.status = ST_FULL;
        end else begin
          slot = links[HEAD_FREE];
          prev = hop_from_head(int'(pos) - 1);
          links[HEAD_FREE] = links[slot];
          values[slot] = val;
          links[slot] = links[prev];
          links[prev] = slot;
          entries++;
        end
      end
      OP_DELETE: begin
        if (pos == 0 || int'(pos) > entries) begin
          a.status = ST_RANGE;
        end else begin
          prev = hop_from_head(int'(pos) - 1);
          slot = links[prev];
          links[prev] = links[slot];
          links[slot] = links[HEAD_FREE];
          links[HEAD_FREE] = slot;
          entries--;
        end
      end
      OP_READ: begin
        if (pos == 0 || int'(pos) > entries) a.status = ST_RANGE;
        else a.rd = values[hop_from_head(int'(pos))];
      end
      default: ;
    endcase
    a.count = COUNT_W'(entries);
    return a;
  endfunction

  // queue a request and track the list length it leaves behind
  function automatic void push_req(logic [OP_W-1:0] op, int pos, logic [VAL_W-1:0] val);
    request_t r;
    r.op = op;
    r.pos = POS_W'(pos);
    r.value = val;
    request_queue.push_back(r);
    total_items++;
    if (op == OP_INSERT && pos >= 1 && pos <= gen_count + 1 && gen_count < int'(MAX_ENTRIES))
      gen_count++;
    else if (op == OP_DELETE && pos >= 1 && pos <= gen_count)
      gen_count--;
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 49) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  always @(negedge clk) begin : drive
    request_t nxt;
    if (rst_n && !(start && accepted < issued)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (request_queue.size() > 0) begin
        nxt = request_queue.pop_front();
        start <= 1'b1;
        req_op <= nxt.op;
        req_pos <= nxt.pos;
        req_value <= nxt.value;
        issued <= issued + 1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    answer_t got;
    answer_t want;
    if (rst_n) begin
      // check the finished request before queueing a new transfer
      if (done) begin
        got.status = status;
        got.rd = read_value;
        got.count = count;
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result status %0d read_value %0d count %0d",
                   $time, got.status, $signed(got.rd), got.count);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, got.status);
            errors++;
          end
          if (got.rd !== want.rd) begin
            $display("%0t: read_value mismatch: expected %0d, got %0d",
                     $time, $signed(want.rd), $signed(got.rd));
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count mismatch: expected %0d, got %0d",
                     $time, want.count, got.count);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        pending_answers.push_back(list_apply(req_op, req_pos, req_value));
        accepted <= accepted + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    traffic_mode_e mode;
    int            r;
    int            pos;
    logic [OP_W-1:0] op;

    for (int i = 0; i < NODES; i++) begin
      links[i] = (i + 2 < NODES) ? LINK_W'(i + 1) : HEAD_FREE;
      values[i] = '0;
    end
    entries = 0;

    // empty list, bad positions, then a few entries at front, middle and end
    push_req(OP_READ, 1, 32'h1234_5678);
    push_req(OP_DELETE, 1, '0);
    push_req(OP_INSERT, 0, 32'hDEAD_BEEF);
    push_req(OP_INSERT, 2, 32'hDEAD_BEEF);
    push_req(OP_INSERT, 1, 32'h7FFF_FFFF);
    push_req(OP_INSERT, 1, 32'h8000_0000);
    push_req(OP_INSERT, 3, 32'h0000_0000);
    push_req(OP_INSERT, 2, 32'hFFFF_FFFF);
    push_req(OP_INSERT, 5, 32'h5555_5555);
    for (int p = 1; p <= 5; p++) push_req(OP_READ, p, 32'hFFFF_FFFF);
    push_req(OP_READ, 0, '0);
    push_req(OP_DELETE, 0, '0);
    push_req(OP_READ, 6, '0);
    push_req(OP_DELETE, 6, '0);
    push_req(OP_UNUSED, 127, 32'hFFFF_FFFF);
    push_req(OP_INSERT, 127, 32'hAAAA_AAAA);
    push_req(OP_DELETE, 3, '0);
    push_req(OP_DELETE, 1, '0);
    push_req(OP_DELETE, 3, '0);
    push_req(OP_READ, 2, '0);

    // phases fill the store toward the top, churn it, then drain it, and repeat
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      mode = traffic_mode_e'((n / PHASE_ITEMS) % 3);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        op = OP_W'($urandom_range(0, 3));
        pos = $urandom_range(0, 127);
      end else begin
        r = $urandom_range(0, 99);
        case (mode)
          GROW:    op = (r < 80) ? OP_INSERT : (r < 85) ? OP_DELETE : OP_READ;
          CHURN:   op = (r < 40) ? OP_INSERT : (r < 75) ? OP_DELETE : OP_READ;
          default: op = (r < 10) ? OP_INSERT : (r < 80) ? OP_DELETE : OP_READ;
        endcase
        if (op == OP_INSERT) pos = $urandom_range(1, gen_count + 1);
        else pos = (gen_count > 0) ? $urandom_range(1, gen_count) : 1;
      end
      push_req(op, pos, $urandom);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (accepted < total_items || pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
